// ===== rtl/core/ipv4_cidr_text_parser_assert.svh =====
// Assertion macros for the CIDR text parser.
// Used by ipv4_cidr_text_parser.sv; expects clk and arst_n in scope.
// Synthesis builds define SYNTHESIS and get empty macros.
`ifndef IPV4_CIDR_TEXT_PARSER_ASSERT_SVH
`define IPV4_CIDR_TEXT_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define ICP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define ICP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ICP_ASSERT(lbl, prop, msg)
`define ICP_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/core/icp_pkg.sv =====
// Types and constants of the CIDR text parser.
// No dependencies; used by ipv4_cidr_text_parser.

package icp_pkg;

	// text limits
	localparam logic [4:0] ADDR_TEXT_LIMIT   = 5'd15;
	localparam logic [2:0] PREFIX_TEXT_LIMIT = 3'd2;

	localparam logic [9:0] MAX_OCTET      = 10'd255;
	localparam logic [6:0] MAX_PREFIX     = 7'd32;
	localparam logic [2:0] OCTET_DIGITS   = 3'd3;
	localparam logic [2:0] LAST_OCTET     = 3'd3;
	localparam logic [4:0] CHAR_COUNT_MAX = 5'd31;

	// ascii codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_ADDR   = 2'd1,
		STATUS_PREFIX = 2'd2
	} status_t;

	typedef struct packed {
		logic [9:0]  octet_value;
		logic [2:0]  digit_count;
		logic [2:0]  octet_index;
		logic [31:0] address_shift;
		logic [4:0]  address_char_count;
		logic        in_prefix_part;
		logic [6:0]  prefix_value;
		status_t     error_code;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		octet_value:        10'd0,
		digit_count:        3'd0,
		octet_index:        3'd0,
		address_shift:      32'd0,
		address_char_count: 5'd0,
		in_prefix_part:     1'b0,
		prefix_value:       7'd0,
		error_code:         STATUS_OK
	};

	// mask with plen leading ones, zero for plen 0
	function automatic logic [31:0] prefix_mask(input logic [6:0] plen);
		prefix_mask = ~(32'hFFFF_FFFF >> plen);
	endfunction

endpackage

// ===== rtl/core/ipv4_cidr_text_parser.sv =====
// CIDR text parser top level: "a.b.c.d/n" in, network address and mask out.
// Depends on icp_pkg and ipv4_cidr_text_parser_assert.svh.
//
// Takes one ASCII character per request on the s_ side, tlast marking the
// final character of a text, and gives one result per text on the m_ side.
// Throughput is one character per cycle: each character is captured in an
// input register and folded into the parser state as it leaves, by a single
// decimal accumulate and compare. A text's result is captured in a result
// register, which drives m_tvalid and decouples the sides, as its final
// character leaves the input register. Only a final character waiting on a
// full result register holds the input, so a stalled consumer costs at most
// the stall time per text. After each result the parser returns to its reset
// state. On any error status the address, mask and prefix fields are zero.

`include "ipv4_cidr_text_parser_assert.svh"

module ipv4_cidr_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_char
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [31:0] net_address, [63:32] net_mask,
	                               // [69:64] prefix_len, [71:70] parse_status
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       fire_s1;

	// parser state
	icp_pkg::parse_state_t parse_q;
	icp_pkg::parse_state_t parse_d;

	// result register
	logic            valid_s2;
	logic [31:0]     net_address_s2;
	logic [31:0]     net_mask_s2;
	logic [5:0]      prefix_len_s2;
	icp_pkg::status_t parse_status_s2;

	// character decode and accumulate
	logic       is_digit;
	logic [7:0] char_off;
	logic [3:0] digit;
	logic [4:0] char_count_inc;
	logic [9:0] octet_acc;
	logic [6:0] prefix_acc;
	logic       close_bad;

	// result of the final character
	icp_pkg::status_t fin_status;
	logic [31:0]      fin_mask;

	// a final character needs room in the result register
	assign fire_s1  = valid_s1 && (!last_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire_s1;

	assign is_digit = (char_s1 >= icp_pkg::CH_ZERO) && (char_s1 <= icp_pkg::CH_NINE);
	assign char_off = char_s1 - icp_pkg::CH_ZERO;
	assign digit    = char_off[3:0];

	assign octet_acc  = parse_q.octet_value * 10'd10 + {6'd0, digit};
	assign prefix_acc = parse_q.prefix_value * 7'd10 + {3'd0, digit};

	assign char_count_inc = (char_s1 != icp_pkg::CH_SLASH &&
		parse_q.address_char_count != icp_pkg::CHAR_COUNT_MAX) ?
		parse_q.address_char_count + 5'd1 : parse_q.address_char_count;

	// octet close fails on a zero first octet, an oversize value or a fifth octet
	assign close_bad = (parse_q.octet_index == 3'd0 && parse_q.octet_value == 10'd0) ||
		(parse_q.octet_value > icp_pkg::MAX_OCTET) ||
		(parse_q.octet_index > icp_pkg::LAST_OCTET);

	// next parser state for the character in the input register
	always_comb begin
		parse_d = parse_q;
		if (parse_q.error_code == icp_pkg::STATUS_OK) begin
			if (!parse_q.in_prefix_part) begin
				parse_d.address_char_count = char_count_inc;
				if (char_s1 != icp_pkg::CH_SLASH && char_count_inc > icp_pkg::ADDR_TEXT_LIMIT) begin
					parse_d.error_code = icp_pkg::STATUS_ADDR;
				end else if (is_digit) begin
					if (parse_q.digit_count >= icp_pkg::OCTET_DIGITS) begin
						parse_d.error_code = icp_pkg::STATUS_ADDR;
					end else begin
						parse_d.octet_value = octet_acc;
						parse_d.digit_count = parse_q.digit_count + 3'd1;
						if (octet_acc > icp_pkg::MAX_OCTET)
							parse_d.error_code = icp_pkg::STATUS_ADDR;
					end
				end else if (char_s1 == icp_pkg::CH_DOT || char_s1 == icp_pkg::CH_SLASH) begin
					// dot needs room for another octet, slash needs exactly the fourth
					if ((char_s1 == icp_pkg::CH_DOT && parse_q.octet_index >= icp_pkg::LAST_OCTET) ||
						(char_s1 == icp_pkg::CH_SLASH && parse_q.octet_index != icp_pkg::LAST_OCTET) ||
						close_bad) begin
						parse_d.error_code = icp_pkg::STATUS_ADDR;
					end else begin
						parse_d.address_shift = {parse_q.address_shift[23:0], parse_q.octet_value[7:0]};
						parse_d.octet_index   = parse_q.octet_index + 3'd1;
						parse_d.octet_value   = 10'd0;
						parse_d.digit_count   = 3'd0;
						if (char_s1 == icp_pkg::CH_SLASH)
							parse_d.in_prefix_part = 1'b1;
					end
				end else begin
					parse_d.error_code = icp_pkg::STATUS_ADDR;
				end
			end else begin
				// prefix part: digits only
				if (!is_digit || parse_q.digit_count >= icp_pkg::PREFIX_TEXT_LIMIT) begin
					parse_d.error_code = icp_pkg::STATUS_PREFIX;
				end else begin
					parse_d.prefix_value = prefix_acc;
					parse_d.digit_count  = parse_q.digit_count + 3'd1;
					if (prefix_acc > icp_pkg::MAX_PREFIX)
						parse_d.error_code = icp_pkg::STATUS_PREFIX;
				end
			end
		end
	end

	// final status: text ending in the address part has no prefix
	always_comb begin
		fin_status = parse_d.error_code;
		if (parse_d.error_code == icp_pkg::STATUS_OK && !parse_d.in_prefix_part)
			fin_status = icp_pkg::STATUS_PREFIX;
	end

	assign fin_mask = icp_pkg::prefix_mask(parse_d.prefix_value);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// parser state, cleared after each final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= icp_pkg::PARSE_RESET;
		end else if (fire_s1) begin
			parse_q <= last_s1 ? icp_pkg::PARSE_RESET : parse_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			parse_status_s2 <= fin_status;
			if (fin_status == icp_pkg::STATUS_OK) begin
				net_address_s2 <= parse_d.address_shift & fin_mask;
				net_mask_s2    <= fin_mask;
				prefix_len_s2  <= parse_d.prefix_value[5:0];
			end else begin
				net_address_s2 <= 32'd0;
				net_mask_s2    <= 32'd0;
				prefix_len_s2  <= 6'd0;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {parse_status_s2, prefix_len_s2, net_mask_s2, net_address_s2};

	// checks
	`ICP_ASSERT(a_err_zero_fields, (valid_s2 && parse_status_s2 != icp_pkg::STATUS_OK) |-> (net_address_s2 == 32'd0 && net_mask_s2 == 32'd0 && prefix_len_s2 == 6'd0), "error result with nonzero fields")
	`ICP_ASSERT_NEVER(a_addr_outside_mask, valid_s2 && ((net_address_s2 & ~net_mask_s2) != 32'd0), "network address has host bits set")
	`ICP_ASSERT_NEVER(a_prefix_range, valid_s2 && parse_status_s2 == icp_pkg::STATUS_OK && prefix_len_s2 > 6'd32, "prefix above 32 reported ok")
	`ICP_ASSERT(a_result_from_last, $rose(valid_s2) |-> $past(valid_s1 && last_s1), "result without a final character")

endmodule
